### sv/qau_pkg.sv
// Shared types, constants and arithmetic helpers for the quaternion arithmetic unit.
`default_nettype none

package qau_pkg;

   // Fixed-point layout and internal widths.
   localparam int QW         = 32;
   localparam int FRAC       = 16;
   localparam int WIDE_W     = QW + 1;
   localparam int PROD_W     = 2 * WIDE_W;
   localparam int TERM_W     = PROD_W - FRAC;
   localparam int SUM_W      = TERM_W + 2;
   localparam int MAG_W      = 49;
   localparam int NUM_W      = QW + FRAC;
   localparam int DIV_STAGES = QW;
   localparam int DIV_W      = MAG_W + QW;

   typedef enum logic [1:0] {
      MODE_MUL  = 2'd0,
      MODE_CONJ = 2'd1,
      MODE_INV  = 2'd2,
      MODE_ROT  = 2'd3
   } mode_type;

   typedef logic signed [QW-1:0] word_type;
   typedef logic [3:0][QW-1:0] quat_type;
   typedef logic [3:0][WIDE_W-1:0] wquat_type;

   localparam word_type QMAX = 32'sh7FFF_FFFF;
   localparam word_type QMIN = 32'sh8000_0000;
   localparam logic [MAG_W-1:0] ONE_Q = MAG_W'(65536);
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(64'sh8000_0000);
   localparam logic [PROD_W-1:0] ROUND_ADJ = PROD_W'(16'hFFFF);

   // Subtracted terms of the Hamilton product, one row per result component.
   // Component r takes p[i] * q[r ^ i].
   localparam logic [3:0][3:0] HAM_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

   typedef struct packed {
      logic [1:0]  mode;
      word_type    a_w;
      word_type    a_x;
      word_type    a_y;
      word_type    a_z;
      word_type    b_w;
      word_type    b_x;
      word_type    b_y;
      word_type    b_z;
   } qau_req_type;

   typedef struct packed {
      word_type    res_w;
      word_type    res_x;
      word_type    res_y;
      word_type    res_z;
      logic        saturated;
   } qau_rsp_type;

   // Per-request information that travels alongside the arithmetic.
   typedef struct packed {
      mode_type              mode;
      logic                  flag;
      quat_type              res;
      quat_type              conj;
      logic [3:0][QW-1:0]    nmag;
      logic [3:0]            nneg;
      logic [MAG_W-1:0]      magsq;
   } side_type;

   typedef struct packed {
      side_type                    side;
      quat_type                    sum;
      logic signed [SUM_W-1:0]     raw_w;
      logic [3:0]                  ovf;
   } ham_type;

   typedef struct packed {
      side_type                    side;
      logic [3:0][NUM_W-1:0]       rem;
      logic [3:0][QW-1:0]          quo;
      logic [3:0]                  ovf;
   } div_type;

   // Sign-extends a word to the operand width of the multipliers.
   function automatic logic [WIDE_W-1:0] widen(input logic [QW-1:0] v);
      return {v[QW-1], v};
   endfunction

   // Drops the fraction bits of a product, rounding toward zero.
   function automatic logic signed [TERM_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] adj;
      adj = p + (p[PROD_W-1] ? ROUND_ADJ : '0);
      return adj[PROD_W-1:FRAC];
   endfunction

   function automatic logic sat_flag(input logic signed [SUM_W-1:0] v);
      return (v > SUM_MAX) || (v < SUM_MIN);
   endfunction

   function automatic word_type sat_word(input logic signed [SUM_W-1:0] v);
      word_type r;
      if (v > SUM_MAX) begin
         r = QMAX;
      end else if (v < SUM_MIN) begin
         r = QMIN;
      end else begin
         r = v[QW-1:0];
      end
      return r;
   endfunction

   // Negation that clamps the most negative value.
   function automatic word_type neg_sat(input word_type v);
      word_type r;
      if (v == QMIN) begin
         r = QMAX;
      end else begin
         r = -v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/qau_ifs.sv
// Request and response channel interfaces of the quaternion arithmetic unit.
`default_nettype none

interface qau_req_if;
   import qau_pkg::*;
   logic        valid;
   logic        ready;
   qau_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface qau_rsp_if;
   import qau_pkg::*;
   logic        valid;
   logic        ready;
   qau_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/quaternion_arithmetic_unit.sv
// Top level of the quaternion arithmetic unit: operand steering and pipeline assembly.
//
// Takes one request per clock and returns one response per request, in order, in signed
// Q16.16: Hamilton product, conjugate, inverse, or rotation of vector b by a as a*v*conj(a).
// Every request passes the same 38 register stages (two for the first Hamilton product, two
// for the second, a divider set-up stage, 32 restoring-divider stages that form one quotient
// bit each, and the output register) whatever the mode. The sustained rate is one request
// per cycle while the response side keeps up. Stalls propagate stage by stage, so empty
// stages keep accepting while a response waits at the output.
`default_nettype none

module quaternion_arithmetic_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   qau_req_if.sink    req_if,
   qau_rsp_if.source  rsp_if
);
   import qau_pkg::*;

   side_type  side0;
   wquat_type h1_p;
   wquat_type h1_q;
   logic      h1_out_valid;
   logic      h1_out_ready;
   ham_type   h1_out;
   side_type  side1;
   wquat_type h2_p;
   wquat_type h2_q;
   logic      h2_out_valid;
   logic      h2_out_ready;
   ham_type   h2_out;
   side_type  side2;

   // Operand steering for the first product and per-request side data.
   always_comb begin
      qau_req_type rq;
      logic [3:0]  cflag;
      word_type    a [4];
      rq   = req_if.payload;
      a[0] = rq.a_w;
      a[1] = rq.a_x;
      a[2] = rq.a_y;
      a[3] = rq.a_z;
      side0       = '0;
      side0.mode  = mode_type'(rq.mode);
      side0.magsq = ONE_Q;
      cflag       = '0;
      side0.conj[0] = a[0];
      for (int i = 1; i < 4; i++) begin
         side0.conj[i] = neg_sat(a[i]);
         cflag[i]      = (a[i] == QMIN);
      end
      side0.res  = side0.conj;
      side0.flag = ((side0.mode == MODE_CONJ) || (side0.mode == MODE_ROT)) && (|cflag);
      // Inverse numerators: the exact conjugate as sign and magnitude.
      side0.nneg[0] = a[0] < 0;
      side0.nmag[0] = (a[0] < 0) ? -a[0] : a[0];
      for (int i = 1; i < 4; i++) begin
         side0.nneg[i] = a[i] > 0;
         side0.nmag[i] = (a[i] < 0) ? -a[i] : a[i];
      end
      for (int i = 0; i < 4; i++) begin
         h1_p[i] = widen(a[i]);
      end
      case (side0.mode)
         MODE_INV: begin
            h1_q[0] = widen(a[0]);
            for (int i = 1; i < 4; i++) begin
               h1_q[i] = -widen(a[i]);
            end
         end
         MODE_ROT: begin
            h1_q[0] = '0;
            h1_q[1] = widen(rq.b_x);
            h1_q[2] = widen(rq.b_y);
            h1_q[3] = widen(rq.b_z);
         end
         default: begin
            h1_q[0] = widen(rq.b_w);
            h1_q[1] = widen(rq.b_x);
            h1_q[2] = widen(rq.b_y);
            h1_q[3] = widen(rq.b_z);
         end
      endcase
   end

   qau_hamilton u_ham1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .p         (h1_p),
      .q         (h1_q),
      .in_side   (side0),
      .out_valid (h1_out_valid),
      .out_ready (h1_out_ready),
      .out_data  (h1_out)
   );

   // Between the products: product result, squared magnitude, rotation operands.
   always_comb begin
      side1 = h1_out.side;
      case (side1.mode)
         MODE_MUL: begin
            side1.res  = h1_out.sum;
            side1.flag = |h1_out.ovf;
         end
         MODE_INV: begin
            if (h1_out.raw_w == '0) begin
               side1.magsq = ONE_Q;
            end else begin
               side1.magsq = h1_out.raw_w[MAG_W-1:0];
            end
         end
         MODE_ROT: begin
            side1.flag = side1.flag || (|h1_out.ovf);
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         h2_p[i] = widen(h1_out.sum[i]);
         h2_q[i] = widen(side1.conj[i]);
      end
   end

   qau_hamilton u_ham2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h1_out_valid),
      .in_ready  (h1_out_ready),
      .p         (h2_p),
      .q         (h2_q),
      .in_side   (side1),
      .out_valid (h2_out_valid),
      .out_ready (h2_out_ready),
      .out_data  (h2_out)
   );

   // Rotation result: vector part of the second product, scalar forced to zero.
   always_comb begin
      side2 = h2_out.side;
      if (side2.mode == MODE_ROT) begin
         side2.res[0] = '0;
         side2.res[1] = h2_out.sum[1];
         side2.res[2] = h2_out.sum[2];
         side2.res[3] = h2_out.sum[3];
         side2.flag   = side2.flag || (|h2_out.ovf);
      end
   end

   qau_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h2_out_valid),
      .in_ready  (h2_out_ready),
      .in_side   (side2),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (rsp_if.payload)
   );

endmodule

`default_nettype wire

### sv/qau_hamilton.sv
// Two-stage pipelined Q16.16 Hamilton product with a side channel.
`default_nettype none

module qau_hamilton (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire qau_pkg::wquat_type p,
   input  wire qau_pkg::wquat_type q,
   input  wire qau_pkg::side_type  in_side,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output qau_pkg::ham_type        out_data
);
   import qau_pkg::*;

   logic                     v1_ff;
   logic                     v2_ff;
   logic signed [PROD_W-1:0] prod_ff [4][4];
   logic signed [PROD_W-1:0] prod_in [4][4];
   side_type                 side1_ff;
   ham_type                  out_ff;
   ham_type                  out_in;
   logic                     rdy1;
   logic                     rdy2;

   // Each stage moves when it is empty or its successor moves.
   assign rdy2      = !v2_ff || out_ready;
   assign rdy1      = !v1_ff || rdy2;
   assign in_ready  = rdy1;
   assign out_valid = v2_ff;
   assign out_data  = out_ff;

   // Stage one: the sixteen exact partial products.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int i = 0; i < 4; i++) begin
            prod_in[r][i] = $signed(p[i]) * $signed(q[2'(r ^ i)]);
         end
      end
   end

   // Stage two: round each term toward zero, add, and clamp.
   always_comb begin
      logic signed [SUM_W-1:0] acc;
      logic signed [SUM_W-1:0] term;
      out_in      = '0;
      out_in.side = side1_ff;
      for (int r = 0; r < 4; r++) begin
         acc = '0;
         for (int i = 0; i < 4; i++) begin
            term = SUM_W'(round_q(prod_ff[r][i]));
            if (HAM_NEG[r][i]) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
         out_in.sum[r] = sat_word(acc);
         out_in.ovf[r] = sat_flag(acc);
         if (r == 0) begin
            out_in.raw_w = acc;
         end
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (rdy1) begin
         prod_ff  <= prod_in;
         side1_ff <= in_side;
      end
      if (rdy2) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

### sv/qau_divider.sv
// Pipelined restoring divider for the inverse, one quotient bit per stage, and result stage.
`default_nettype none

module qau_divider (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire qau_pkg::side_type  in_side,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output qau_pkg::qau_rsp_type    out_data
);
   import qau_pkg::*;

   logic [DIV_STAGES:0] v_ff;
   logic [DIV_STAGES:0] rdy;
   div_type             st_ff [DIV_STAGES+1];
   div_type             st_in [DIV_STAGES+1];
   logic                out_v_ff;
   mode_type            out_mode_ff;
   qau_rsp_type         out_ff;
   qau_rsp_type         out_in;
   logic                out_rdy;

   assign out_rdy   = !out_v_ff || out_ready;
   assign in_ready  = rdy[0];
   assign out_valid = out_v_ff;
   assign out_data  = out_ff;

   // Ready chain from the output register back to the first stage.
   always_comb begin
      rdy[DIV_STAGES] = !v_ff[DIV_STAGES] || out_rdy;
      for (int k = DIV_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   // Prepare the scaled numerators and the overflow test, then one bit per stage.
   always_comb begin
      logic [DIV_W-1:0] cand;
      logic [DIV_W-1:0] top;
      st_in[0]      = '0;
      st_in[0].side = in_side;
      top           = {in_side.magsq, {QW{1'b0}}};
      for (int c = 0; c < 4; c++) begin
         st_in[0].rem[c] = {in_side.nmag[c], {FRAC{1'b0}}};
         st_in[0].ovf[c] = DIV_W'(st_in[0].rem[c]) >= top;
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
         st_in[k] = st_ff[k-1];
         cand     = {st_ff[k-1].side.magsq, {QW{1'b0}}} >> k;
         for (int c = 0; c < 4; c++) begin
            if (DIV_W'(st_ff[k-1].rem[c]) >= cand) begin
               st_in[k].rem[c] = st_ff[k-1].rem[c] - cand[NUM_W-1:0];
               st_in[k].quo[c][5'(DIV_STAGES - k)] = 1'b1;
            end
         end
      end
   end

   // Result stage: sign and clamp the quotients, or pass the other modes through.
   always_comb begin
      div_type  last;
      logic     flag;
      quat_type res;
      last = st_ff[DIV_STAGES];
      flag = last.side.flag;
      res  = last.side.res;
      if (last.side.mode == MODE_INV) begin
         for (int c = 0; c < 4; c++) begin
            if (last.ovf[c]) begin
               res[c] = last.side.nneg[c] ? QMIN : QMAX;
               flag   = 1'b1;
            end else if (!last.side.nneg[c]) begin
               if (last.quo[c][QW-1]) begin
                  res[c] = QMAX;
                  flag   = 1'b1;
               end else begin
                  res[c] = last.quo[c];
               end
            end else begin
               if (last.quo[c][QW-1] && (|last.quo[c][QW-2:0])) begin
                  res[c] = QMIN;
                  flag   = 1'b1;
               end else begin
                  res[c] = -last.quo[c];
               end
            end
         end
      end
      out_in.res_w     = res[0];
      out_in.res_x     = res[1];
      out_in.res_y     = res[2];
      out_in.res_z     = res[3];
      out_in.saturated = flag;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k <= DIV_STAGES; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
         if (out_rdy) begin
            out_v_ff <= v_ff[DIV_STAGES];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
         if (rdy[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
      if (out_rdy) begin
         out_ff      <= out_in;
         out_mode_ff <= st_ff[DIV_STAGES].side.mode;
      end
   end

`ifndef SYNTHESIS
   // A rotation never reports a scalar part.
   a_rot_w_zero: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && (out_mode_ff == MODE_ROT) |-> out_ff.res_w == '0)
      else $error("rotation result has nonzero scalar part");

   // After the last bit the scalar remainder is below the divisor unless it overflowed.
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      v_ff[DIV_STAGES] && (st_ff[DIV_STAGES].side.mode == MODE_INV)
      && !st_ff[DIV_STAGES].ovf[0]
      |-> MAG_W'(st_ff[DIV_STAGES].rem[0]) < st_ff[DIV_STAGES].side.magsq)
      else $error("divider remainder not reduced");

   // The divisor entering the divider is never zero.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] && (st_ff[0].side.mode == MODE_INV) |-> st_ff[0].side.magsq != '0)
      else $error("zero divisor in divider");
`endif

endmodule

`default_nettype wire

### bench/qau_ifs_bench.sv
// Note: the interfaces come from the RTL file set; this file only holds the bench clock gen helper.
`timescale 1ns / 1ps
`default_nettype none

module qau_clock_gen (
   output logic clock
);
   // Free-running clock with a 4 ns period.
   initial begin
      clock = 1'b0;
   end
   always begin
      #2 clock = ~clock;
   end
endmodule

`default_nettype wire

### bench/quaternion_arithmetic_unit_test.sv
// Testbench for the quaternion arithmetic unit: random and directed requests checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_arithmetic_unit_test;
   import qau_pkg::*;

   localparam int LATENCY = 38;
   localparam int STALL_LIMIT = 4000;

   logic clock;
   logic reset;
   logic rsp_hold;
   logic quiet;
   int   failures;
   int   idle_cycles;

   qau_req_if req_if ();
   qau_rsp_if rsp_if ();
   qau_rsp_type expected_results[$];

   qau_clock_gen clock_gen (.clock(clock));

   quaternion_arithmetic_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   // Q16.16 product, truncated toward zero, kept exact.
   function automatic longint qprod(input longint x, input longint y);
      longint m;
      m = ((x < 0 ? -x : x) * (y < 0 ? -y : y)) >>> 16;
      return ((x < 0) != (y < 0)) ? -m : m;
   endfunction

   function automatic longint clamp32(input longint v, inout logic flag);
      longint r;
      r = v;
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         r = 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         flag = 1'b1;
         r = -64'sd2147483648;
      end
      return r;
   endfunction

   function automatic void hamilton_product(input longint p[4], input longint q[4],
                                            output longint r[4], inout logic flag);
      r[0] = clamp32(qprod(p[0], q[0]) - qprod(p[1], q[1]) - qprod(p[2], q[2])
                     - qprod(p[3], q[3]), flag);
      r[1] = clamp32(qprod(p[0], q[1]) + qprod(p[1], q[0]) + qprod(p[2], q[3])
                     - qprod(p[3], q[2]), flag);
      r[2] = clamp32(qprod(p[0], q[2]) - qprod(p[1], q[3]) + qprod(p[2], q[0])
                     + qprod(p[3], q[1]), flag);
      r[3] = clamp32(qprod(p[0], q[3]) + qprod(p[1], q[2]) - qprod(p[2], q[1])
                     + qprod(p[3], q[0]), flag);
   endfunction

   // Quotient (n * 2^16) / d, truncated toward zero.
   function automatic longint qquot(input longint n, input longint d);
      longint m;
      m = ((n < 0 ? -n : n) <<< 16) / d;
      return n < 0 ? -m : m;
   endfunction

   // Expected response of the unit for one request.
   function automatic qau_rsp_type quaternion_result(input qau_req_type rq);
      longint a[4], b[4], v[4], r[4], t[4], p[4];
      longint magsq;
      logic flag;
      qau_rsp_type rs;
      flag = 1'b0;
      a[0] = longint'(rq.a_w); a[1] = longint'(rq.a_x);
      a[2] = longint'(rq.a_y); a[3] = longint'(rq.a_z);
      b[0] = longint'(rq.b_w); b[1] = longint'(rq.b_x);
      b[2] = longint'(rq.b_y); b[3] = longint'(rq.b_z);
      case (mode_type'(rq.mode))
         MODE_MUL: begin
            hamilton_product(a, b, r, flag);
         end
         MODE_CONJ: begin
            r[0] = a[0];
            for (int i = 1; i < 4; i++) r[i] = clamp32(-a[i], flag);
         end
         MODE_INV: begin
            magsq = 0;
            for (int i = 0; i < 4; i++) magsq += qprod(a[i], a[i]);
            if (magsq == 0) magsq = 65536;
            r[0] = clamp32(qquot(a[0], magsq), flag);
            for (int i = 1; i < 4; i++) r[i] = clamp32(qquot(-a[i], magsq), flag);
         end
         default: begin
            v[0] = 0; v[1] = b[1]; v[2] = b[2]; v[3] = b[3];
            hamilton_product(a, v, t, flag);
            p[0] = a[0];
            for (int i = 1; i < 4; i++) p[i] = clamp32(-a[i], flag);
            hamilton_product(t, p, r, flag);
            r[0] = 0;
         end
      endcase
      rs.res_w = word_type'(r[0]);
      rs.res_x = word_type'(r[1]);
      rs.res_y = word_type'(r[2]);
      rs.res_z = word_type'(r[3]);
      rs.saturated = flag;
      return rs;
   endfunction

   // Operand word biased toward extremes and small magnitudes.
   function automatic word_type random_word();
      word_type w;
      case ($urandom_range(0, 7))
         0: w = QMIN;
         1: w = QMAX;
         2: w = word_type'($urandom_range(0, 2)) - 1;
         3, 4: w = word_type'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
         5: w = word_type'($signed($urandom_range(0, 32'h3FF)) - 32'sh200);
         default: w = word_type'($urandom);
      endcase
      return w;
   endfunction

   // Sends one request, with a random gap before it unless idling is off.
   task automatic send_request(input qau_req_type rq);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_if.payload <= rq;
      req_if.valid <= 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_results.push_back(quaternion_result(rq));
      @(negedge clock);
   endtask

   task automatic send_fields(input mode_type m, input word_type aw, input word_type ax,
                              input word_type ay, input word_type az, input word_type bw,
                              input word_type bx, input word_type by, input word_type bz);
      qau_req_type rq;
      rq.mode = m;
      rq.a_w = aw; rq.a_x = ax; rq.a_y = ay; rq.a_z = az;
      rq.b_w = bw; rq.b_x = bx; rq.b_y = by; rq.b_z = bz;
      send_request(rq);
   endtask

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++) begin
         send_fields(mode_type'($urandom_range(0, 3)), random_word(), random_word(),
                     random_word(), random_word(), random_word(), random_word(),
                     random_word(), random_word());
      end
   endtask

   task automatic drain_requests();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   // Directed corners: every mode, extremes, zero magnitude, most negative negation.
   task automatic test_directed();
      word_type one;
      one = 32'sh1_0000;
      send_fields(MODE_MUL, one, 0, 0, 0, 32'sh2_0000, one, -one, 32'sh8000);
      send_fields(MODE_MUL, QMAX, QMAX, QMAX, QMAX, QMAX, QMIN, QMAX, QMIN);
      send_fields(MODE_MUL, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN);
      send_fields(MODE_MUL, -1, 1, -1, 1, -1, -1, 1, 1);
      send_fields(MODE_CONJ, QMIN, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMAX);
      send_fields(MODE_CONJ, QMAX, QMAX, 0, -1, 0, 0, 0, 0);
      send_fields(MODE_INV, 0, 0, 0, 0, QMIN, QMIN, QMIN, QMIN);
      send_fields(MODE_INV, 1, -1, 255, -255, 0, 0, 0, 0);
      send_fields(MODE_INV, one, 0, 0, 0, 0, 0, 0, 0);
      send_fields(MODE_INV, 32'sh8000, 32'sh8000, -32'sh8000, 32'sh8000, 0, 0, 0, 0);
      send_fields(MODE_INV, QMIN, QMAX, QMIN, QMAX, 0, 0, 0, 0);
      send_fields(MODE_INV, 256, 0, 0, 0, 0, 0, 0, 0);
      send_fields(MODE_ROT, one, 0, 0, 0, QMAX, one, 32'sh2_0000, -one);
      send_fields(MODE_ROT, 32'shB505, 0, 0, 32'shB505, QMIN, one, 0, 0);
      send_fields(MODE_ROT, QMIN, QMIN, QMIN, QMIN, 0, QMAX, QMIN, QMAX);
      send_fields(MODE_ROT, 0, QMIN, 0, 0, 0, one, one, one);
      send_fields(MODE_ROT, 32'sh100_0000, 32'sh100_0000, 0, 0, 0, 0, 32'sh100_0000, 0);
   endtask

   // Receiver holds off while requests keep coming, so the pipeline backs up.
   task automatic test_backpressure();
      fork
         begin
            rsp_hold = 1'b1;
            repeat (3 * LATENCY) @(posedge clock);
            rsp_hold = 1'b0;
         end
         send_random(80);
      join
      drain_requests();
   endtask

   task automatic test_random();
      send_random(850);
      drain_requests();
   endtask

   task automatic test_streaming();
      quiet = 1'b1;
      send_random(100);
      drain_requests();
   endtask

   // Response ready with random stall bursts.
   initial begin
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_if.ready <= 1'b0;
            @(negedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Compares each accepted response with the oldest expected one.
   always @(posedge clock) begin
      qau_rsp_type exp_rsp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected response %h", rsp_if.payload);
            failures++;
         end else begin
            exp_rsp = expected_results.pop_front();
            if (rsp_if.payload.res_w !== exp_rsp.res_w) begin
               $error("res_w expected %h got %h", exp_rsp.res_w, rsp_if.payload.res_w);
               failures++;
            end
            if (rsp_if.payload.res_x !== exp_rsp.res_x) begin
               $error("res_x expected %h got %h", exp_rsp.res_x, rsp_if.payload.res_x);
               failures++;
            end
            if (rsp_if.payload.res_y !== exp_rsp.res_y) begin
               $error("res_y expected %h got %h", exp_rsp.res_y, rsp_if.payload.res_y);
               failures++;
            end
            if (rsp_if.payload.res_z !== exp_rsp.res_z) begin
               $error("res_z expected %h got %h", exp_rsp.res_z, rsp_if.payload.res_z);
               failures++;
            end
            if (rsp_if.payload.saturated !== exp_rsp.saturated) begin
               $error("saturated expected %b got %b", exp_rsp.saturated,
                      rsp_if.payload.saturated);
               failures++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted request or response.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("quaternion_arithmetic_unit_test: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      failures = 0;
      idle_cycles = 0;
      rsp_hold = 1'b0;
      quiet = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      drain_requests();
      test_backpressure();
      test_random();
      test_streaming();
      repeat (LATENCY + 10) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("quaternion_arithmetic_unit_test: done, clean");
      end else begin
         $display("quaternion_arithmetic_unit_test: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
sv/qau_pkg.sv
sv/qau_ifs.sv
sv/qau_hamilton.sv
sv/qau_divider.sv
sv/quaternion_arithmetic_unit.sv
bench/qau_ifs_bench.sv
bench/quaternion_arithmetic_unit_test.sv
